@@ hdl/fnv_mix_hash_printable_unit_assert.svh @@
// ----------------------------------------------------------------------------
// fnv mix hash assertion macros
// concurrent assertion wrappers, empty when NO_ASSERTIONS is defined
// ----------------------------------------------------------------------------
`ifndef FNV_MIX_HASH_PRINTABLE_UNIT_ASSERT_SVH
`define FNV_MIX_HASH_PRINTABLE_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// condition in a cycle implies consequence in the same cycle
`define FNVMH_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fnv mix hash: assertion failed");

// condition in a cycle implies consequence in the next cycle
`define FNVMH_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fnv mix hash: assertion failed");

`else

`define FNVMH_ASSERT_SAME(label, clk, rst, ante, cons)
`define FNVMH_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

@@ hdl/fnvmh_pkg.sv @@
// ----------------------------------------------------------------------------
// fnv mix hash package
// hash constants and the per-byte and finishing mix functions
// ----------------------------------------------------------------------------
package fnvmh_pkg;

  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;
  // prime times (1 + 2^10), folds the shift-add into the multiply
  localparam logic [31:0] PRIME_MIX = 32'h0106_4D93;
  // ceil(2^37 / 47), exact quotient for any 31-bit dividend
  localparam logic [31:0] RECIP_47  = 32'd2924233053;
  localparam int          RECIP_SHIFT = 37;
  localparam logic [6:0]  CHAR_BASE = 7'd33;
  localparam logic [5:0]  HALF_MOD  = 6'd47;

  function automatic logic [31:0] absorb(input logic [31:0] h, input logic [7:0] b);
    logic [31:0] m;
    m = (h ^ {24'b0, b}) * PRIME_MIX;
    return m ^ (m >> 6);
  endfunction

  function automatic logic [31:0] finish(input logic [31:0] h);
    logic [31:0] a;
    logic [31:0] t;
    a = h + (h << 3);
    t = a ^ (a >> 11);
    return t + (t << 15);
  endfunction

endpackage

@@ hdl/fnv_mix_hash_printable_unit.sv @@
// path: a final byte passes the input register, finish stage, emitter and
//   quotient stage, then one character per cycle while out_ready is high
// throughput: one byte per cycle unless a final byte waits on the finish stage;
//   each digest gives DIGEST_CHARS characters, walked out of the finished hash
// reset: synchronous active-high rst empties every stage and loads the basis
// ----------------------------------------------------------------------------
// fnv mix hash printable unit
// byte-serial fnv-1a hash with shift mixing and a printable character digest
// ----------------------------------------------------------------------------
`include "fnv_mix_hash_printable_unit_assert.svh"

module fnv_mix_hash_printable_unit #(
  parameter int DIGEST_CHARS = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [6:0]  print_char,
  output logic [2:0]  char_index,
  output logic [31:0] final_hash,
  output logic        last_char
);

  import fnvmh_pkg::*;

  // digest length kept inside 1..8
  localparam int NCHARS = (DIGEST_CHARS < 1) ? 1 : ((DIGEST_CHARS > 8) ? 8 : DIGEST_CHARS);
  localparam logic [2:0] LAST_IDX = 3'(NCHARS - 1);

  // input register: one byte waiting to be absorbed
  logic        ib_valid;
  logic [7:0]  ib_byte;
  logic        ib_eom;
  logic        ib_go;

  // running hash of the bytes absorbed so far in a message
  logic [31:0] running_hash;
  logic [31:0] hash_abs;

  // finish stage: absorbed hash of a final byte
  logic        fs_valid;
  logic [31:0] fs_hash;
  logic        fs_go;
  logic        fs_free;

  // character emitter: hash shifted right by four per character
  logic        em_valid;
  logic [31:0] em_w;
  logic [31:0] em_fin;
  logic [2:0]  em_idx;
  logic        em_last;
  logic        em_go;
  logic        em_free;
  logic [42:0] em_prod;

  // quotient stage: low bits of w/94 quotient
  logic        p1_valid;
  logic [5:0]  p1_q6;
  logic [6:0]  p1_lo;
  logic [2:0]  p1_idx;
  logic [31:0] p1_fin;
  logic        p1_last;
  logic        p1_go;
  logic [5:0]  p1_rem;

  // ---------------------------------------------------------------------------
  // flow control, one step back from the output register
  // ---------------------------------------------------------------------------
  assign p1_go   = !out_valid || out_ready;
  assign em_go   = em_valid && (!p1_valid || p1_go);
  assign em_last = (em_idx == LAST_IDX);
  // emitter can take a new digest once its final character moves on
  assign em_free = !em_valid || (em_go && em_last);
  assign fs_go   = fs_valid && em_free;
  assign fs_free = !fs_valid || fs_go;
  // a plain byte always absorbs; a final byte needs the finish stage free
  assign ib_go   = ib_valid && (!ib_eom || fs_free);
  assign in_ready = !ib_valid || ib_go;

  assign hash_abs = absorb(running_hash, ib_byte);

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      ib_valid <= 1'b0;
    end else if (in_ready) begin
      ib_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      ib_byte <= data_byte;
      ib_eom  <= end_of_message;
    end
  end

  // running hash, back to the basis after each final byte
  always_ff @(posedge clk) begin
    if (rst) begin
      running_hash <= FNV_BASIS;
    end else if (ib_go) begin
      running_hash <= ib_eom ? FNV_BASIS : hash_abs;
    end
  end

  // finish stage
  always_ff @(posedge clk) begin
    if (rst) begin
      fs_valid <= 1'b0;
    end else if (fs_free) begin
      fs_valid <= ib_go && ib_eom;
    end
    if (fs_free && ib_go && ib_eom) begin
      fs_hash <= hash_abs;
    end
  end

  // character emitter
  always_ff @(posedge clk) begin
    if (rst) begin
      em_valid <= 1'b0;
    end else if (fs_go) begin
      em_valid <= 1'b1;
    end else if (em_go && em_last) begin
      em_valid <= 1'b0;
    end
    if (fs_go) begin
      em_fin <= finish(fs_hash);
      em_w   <= finish(fs_hash);
      em_idx <= '0;
    end else if (em_go) begin
      em_w   <= em_w >> 4;
      em_idx <= em_idx + 3'd1;
    end
  end

  // w mod 94 = 2 * ((w >> 1) mod 47) + w[0]; only quotient bits 5..0 are
  // needed since the remainder is below 64
  assign em_prod = 43'(em_w[31:1]) * 43'(RECIP_47);

  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
    end else if (!p1_valid || p1_go) begin
      p1_valid <= em_go;
    end
    if (em_go) begin
      p1_q6   <= em_prod[RECIP_SHIFT +: 6];
      p1_lo   <= em_w[6:0];
      p1_idx  <= em_idx;
      p1_fin  <= em_fin;
      p1_last <= em_last;
    end
  end

  // remainder by 47 in six-bit arithmetic
  assign p1_rem = p1_lo[6:1] - 6'(p1_q6 * HALF_MOD);

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (p1_go) begin
      out_valid <= p1_valid;
    end
    if (p1_go && p1_valid) begin
      print_char <= 7'({p1_rem, p1_lo[0]}) + CHAR_BASE;
      char_index <= p1_idx;
      final_hash <= p1_fin;
      last_char  <= p1_last;
    end
  end

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  `FNVMH_ASSERT_NEXT(a_emit_step, clk, rst, em_go && !em_last && !fs_go,
    em_valid && (em_idx == $past(em_idx) + 3'd1))
  `FNVMH_ASSERT_NEXT(a_basis_after_msg, clk, rst, ib_go && ib_eom,
    running_hash == FNV_BASIS)
  `FNVMH_ASSERT_NEXT(a_finish_hold, clk, rst, fs_valid && !fs_go,
    fs_valid && $stable(fs_hash))
  `FNVMH_ASSERT_SAME(a_char_range, clk, rst, out_valid,
    (print_char >= 7'd33) && (print_char <= 7'd126))
  `FNVMH_ASSERT_SAME(a_last_index, clk, rst, out_valid,
    last_char == (char_index == LAST_IDX))

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fnv mix hash printable unit testbench
// streams byte messages through the hashing unit under several flow-control
// patterns and checks every digest character against an in-bench hash model
// ----------------------------------------------------------------------------

module tb_top;

  import fnvmh_pkg::FNV_BASIS;
  import fnvmh_pkg::FNV_PRIME;

  localparam int DIGEST_N     = 8;
  // cycles with no transfer on either side before the run is declared hung
  localparam int STALL_LIMIT  = 2000;
  // pipeline tail waited out at the end of each phase once no character is owed
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_BYTES = 78;

  // one digest character as the unit should present it
  typedef struct packed {
    logic [6:0]  ch;
    logic [2:0]  idx;
    logic [31:0] fin_hash;
    logic        last;
  } digest_char_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'h00;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [6:0]  print_char;
  logic [2:0]  char_index;
  logic [31:0] final_hash;
  logic        last_char;

  // hash model state and the characters still owed by the unit
  logic [31:0]  hash_state = FNV_BASIS;
  digest_char_t digest_q[$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int fail_count     = 0;
  int bytes_sent     = 0;
  int msgs_sent      = 0;
  int chars_checked  = 0;
  int quiet_cycles   = 0;

  fnv_mix_hash_printable_unit #(
    .DIGEST_CHARS(DIGEST_N)
  ) dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .data_byte      (data_byte),
    .end_of_message (end_of_message),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .print_char     (print_char),
    .char_index     (char_index),
    .final_hash     (final_hash),
    .last_char      (last_char)
  );

  // 2 ns clock
  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // --------------------------------------------------------------------------
  // hash model
  // --------------------------------------------------------------------------

  // fnv-1a step followed by the shift-add and shift-xor mix
  function automatic logic [31:0] mix_byte(input logic [31:0] h, input logic [7:0] b);
    h = (h ^ {24'h0, b}) * FNV_PRIME;
    h = h + (h << 10);
    h = h ^ (h >> 6);
    return h;
  endfunction

  // three-step avalanche applied once per message
  function automatic logic [31:0] avalanche_mix(input logic [31:0] h);
    h = h + (h << 3);
    h = h ^ (h >> 11);
    h = h + (h << 15);
    return h;
  endfunction

  // fold one transferred byte into the model; the end byte queues a digest
  task automatic predict_byte(input logic [7:0] b, input logic eom);
    logic [31:0]  h;
    logic [31:0]  w;
    digest_char_t c;
    h = mix_byte(hash_state, b);
    if (!eom) begin
      hash_state = h;
    end else begin
      c.fin_hash = avalanche_mix(h);
      w = c.fin_hash;
      for (int k = 0; k < DIGEST_N; k++) begin
        c.ch   = 7'((w % 32'd94) + 32'd33);
        c.idx  = 3'(k);
        c.last = (k == DIGEST_N - 1);
        digest_q.push_back(c);
        w = w >> 4;
      end
      hash_state = FNV_BASIS;
    end
  endtask

  // --------------------------------------------------------------------------
  // input side: one byte per call, entered and left at a falling edge
  // --------------------------------------------------------------------------

  task automatic send_byte(input logic [7:0] b, input logic eom);
    // random idle gap before the byte, valid dropped meanwhile
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    end_of_message <= eom;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // transfer taken at this edge
    predict_byte(b, eom);
    bytes_sent++;
    if (eom) msgs_sent++;
    @(negedge clk);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) begin
      send_byte(8'($urandom_range(255)), i == len - 1);
    end
  endtask

  // drop valid, then wait for every owed character and the pipeline tail
  task automatic quiesce();
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    @(negedge clk);
  endtask

  // mostly short messages, now and then a long one
  task automatic random_messages(input int n_bytes, input int idle, input int stall);
    int target;
    int len;
    send_idle_pct  = idle;
    recv_stall_pct = stall;
    target = bytes_sent + n_bytes;
    while (bytes_sent < target) begin
      if ($urandom_range(9) == 0) len = $urandom_range(40, 7);
      else len = $urandom_range(6, 1);
      send_message(len);
    end
    quiesce();
  endtask

  // --------------------------------------------------------------------------
  // output side: random stalls and the digest check
  // --------------------------------------------------------------------------

  always @(negedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin : check_digest
    digest_char_t want;
    if (!rst && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        $error("digest character with none outstanding: char %0d index %0d",
               print_char, char_index);
        fail_count++;
      end else begin
        want = digest_q.pop_front();
        chars_checked++;
        if (print_char !== want.ch) begin
          $error("print_char mismatch: expected %0d, got %0d", want.ch, print_char);
          fail_count++;
        end
        if (char_index !== want.idx) begin
          $error("char_index mismatch: expected %0d, got %0d", want.idx, char_index);
          fail_count++;
        end
        if (final_hash !== want.fin_hash) begin
          $error("final_hash mismatch: expected %h, got %h", want.fin_hash, final_hash);
          fail_count++;
        end
        if (last_char !== want.last) begin
          $error("last_char mismatch: expected %0d, got %0d", want.last, last_char);
          fail_count++;
        end
      end
    end
  end

  // watchdog on transfers in either direction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("timeout: no transfer for %0d cycles, %0d characters outstanding",
               STALL_LIMIT, digest_q.size());
      $display("Some tests failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // tests
  // --------------------------------------------------------------------------

  // one-byte messages: every byte is also the final byte of its message
  task automatic test_one_byte_messages();
    logic [7:0] vals[7] = '{8'h00, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA};
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    foreach (vals[i]) send_byte(vals[i], 1'b1);
    quiesce();
  endtask

  // longer messages back to back, checks the return to the basis between them
  task automatic test_multi_byte_messages();
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    // same bytes again, digest must repeat
    send_byte(8'h61, 1'b0);
    send_byte(8'h62, 1'b0);
    send_byte(8'h63, 1'b1);
    quiesce();
  endtask

  task automatic test_free_flow();
    random_messages(RANDOM_BYTES, 0, 0);
  endtask

  task automatic test_sparse_input();
    random_messages(RANDOM_BYTES, 81, 0);
  endtask

  task automatic test_heavy_backpressure();
    random_messages(RANDOM_BYTES, 0, 81);
  endtask

  task automatic test_mixed_idling();
    random_messages(RANDOM_BYTES, 23, 23);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_one_byte_messages();
    test_multi_byte_messages();
    test_free_flow();
    test_sparse_input();
    test_heavy_backpressure();
    test_mixed_idling();

    if (digest_q.size() != 0) begin
      $error("%0d digest characters never arrived", digest_q.size());
      fail_count++;
    end

    $display("hashed %0d bytes in %0d messages, %0d digest characters checked",
             bytes_sent, msgs_sent, chars_checked);
    $display("flow phases: free flow, sparse input, heavy backpressure, mixed idling");
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
